// File: design/irc_mlp_pkg.sv
// Shared types and constants for the IRC message line parser.
// No dependencies; used by irc_mlp_core and irc_message_line_parser.
package irc_mlp_pkg;

   localparam int MAX_PARAMS_DEF = 15;
   localparam int MAX_LINE_DEF   = 512;

   localparam int BYTE_W   = 8;
   localparam int ROLE_W   = 3;
   localparam int TOKEN_W  = 5;
   localparam int ARG_W    = 4;
   localparam int STATUS_W = 2;
   localparam int CMD_W    = 10;
   localparam int SRC_W    = 9;
   localparam int CLEN_W   = 3;

   localparam logic [ROLE_W-1:0] ROLE_DROP   = 3'd0;
   localparam logic [ROLE_W-1:0] ROLE_PREFIX = 3'd1;
   localparam logic [ROLE_W-1:0] ROLE_CMD    = 3'd2;
   localparam logic [ROLE_W-1:0] ROLE_DEST   = 3'd3;
   localparam logic [ROLE_W-1:0] ROLE_MIDDLE = 3'd4;
   localparam logic [ROLE_W-1:0] ROLE_TRAIL  = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_TOO_MANY = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_TOO_FEW  = 2'd2;

   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_BANG  = 8'h21;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CH_AT    = 8'h40;

   localparam logic [CMD_W-1:0]  NONE_SEEN    = 10'h3FF;
   localparam logic [SRC_W-1:0]  SRC_SAT      = 9'h1FF;
   localparam logic [CLEN_W-1:0] CMD_DIGITS   = 3'd3;
   localparam logic [CLEN_W-1:0] CMD_LEN_CAP  = 3'd4;

   typedef struct packed {
      logic [ROLE_W-1:0]   byte_role;
      logic [TOKEN_W-1:0]  token_number;
      logic [ARG_W-1:0]    argument_number;
      logic                line_done;
      logic [STATUS_W-1:0] parse_status;
      logic [CMD_W-1:0]    command_number;
      logic [ARG_W-1:0]    argument_count;
      logic                prefix_present;
      logic [SRC_W-1:0]    source_length;
   } result_type;

endpackage

// File: design/irc_message_line_parser.sv
// IRC message line parser: takes one byte word per clock and returns one tagged word per byte.
// Each byte passes an input register, then a result register, and the sustained rate is one
// byte per clock, set by the per-word line-state update in irc_mlp_core; both sides may
// stall freely. The result word for the byte marked line_end carries the line summary, and the
// line state clears behind it so the next line may follow in the very next cycle.
// Depends on irc_mlp_pkg and irc_mlp_core.
module irc_message_line_parser #(
   parameter int MAX_PARAMS = irc_mlp_pkg::MAX_PARAMS_DEF,
   parameter int MAX_LINE   = irc_mlp_pkg::MAX_LINE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [irc_mlp_pkg::BYTE_W-1:0]    req_line_byte,
   input  logic                              req_line_end,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [irc_mlp_pkg::ROLE_W-1:0]    rsp_byte_role,
   output logic [irc_mlp_pkg::TOKEN_W-1:0]   rsp_token_number,
   output logic [irc_mlp_pkg::ARG_W-1:0]     rsp_argument_number,
   output logic                              rsp_line_done,
   output logic [irc_mlp_pkg::STATUS_W-1:0]  rsp_parse_status,
   output logic [irc_mlp_pkg::CMD_W-1:0]     rsp_command_number,
   output logic [irc_mlp_pkg::ARG_W-1:0]     rsp_argument_count,
   output logic                              rsp_prefix_present,
   output logic [irc_mlp_pkg::SRC_W-1:0]     rsp_source_length
);
   import irc_mlp_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_end_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;
   result_type        step_result;
   logic              advance;
   logic              req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_line_byte;
         in_end_ff  <= req_line_end;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   irc_mlp_core #(
      .MAX_PARAMS (MAX_PARAMS),
      .MAX_LINE   (MAX_LINE)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .line_byte (in_byte_ff),
      .line_end  (in_end_ff),
      .result    (step_result)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_byte_role       = rsp_data_ff.byte_role;
   assign rsp_token_number    = rsp_data_ff.token_number;
   assign rsp_argument_number = rsp_data_ff.argument_number;
   assign rsp_line_done       = rsp_data_ff.line_done;
   assign rsp_parse_status    = rsp_data_ff.parse_status;
   assign rsp_command_number  = rsp_data_ff.command_number;
   assign rsp_argument_count  = rsp_data_ff.argument_count;
   assign rsp_prefix_present  = rsp_data_ff.prefix_present;
   assign rsp_source_length   = rsp_data_ff.source_length;

   a_summary_only_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_line_done |-> rsp_parse_status == STAT_OK
         && rsp_command_number == '0 && rsp_argument_count == '0
         && !rsp_prefix_present && rsp_source_length == '0)
      else $error("summary fields set on a word that does not end the line");

   a_error_clears_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parse_status != STAT_OK |-> rsp_command_number == '0
         && rsp_argument_count == '0 && rsp_source_length == '0)
      else $error("error line reports nonzero summary values");

   a_drop_has_no_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_role == ROLE_DROP |-> rsp_token_number == '0
         && rsp_argument_number == '0)
      else $error("dropped byte carries a token or argument index");

   a_arg_only_for_args: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_role != ROLE_MIDDLE && rsp_byte_role != ROLE_TRAIL
         |-> rsp_argument_number == '0)
      else $error("argument index on a non-argument byte");

   a_no_source_without_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_done && !rsp_prefix_present |-> rsp_source_length == '0)
      else $error("source length reported for a line without prefix");

endmodule

// File: design/irc_mlp_core.sv
// Line state and per-word tagging for the IRC message line parser.
// Depends on irc_mlp_pkg; result is combinational from state and the input word.
module irc_mlp_core #(
   parameter int MAX_PARAMS = irc_mlp_pkg::MAX_PARAMS_DEF,
   parameter int MAX_LINE   = irc_mlp_pkg::MAX_LINE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step_en,
   input  logic [irc_mlp_pkg::BYTE_W-1:0]  line_byte,
   input  logic                            line_end,
   output irc_mlp_pkg::result_type         result
);
   import irc_mlp_pkg::*;

   localparam int TOKEN_LIMIT = MAX_PARAMS + 3;
   localparam int TC_W        = $clog2(TOKEN_LIMIT + 1);
   localparam int TCX_W       = (TC_W > TOKEN_W) ? TC_W : TOKEN_W;
   localparam int POS_W       = $clog2(MAX_LINE + 1);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              in_token_ff, in_token_in;
   logic              in_trail_ff, in_trail_in;
   logic              stopped_ff, stopped_in;
   logic [TC_W-1:0]   tc_ff, tc_in;
   logic              has_pfx_ff, has_pfx_in;
   logic [SRC_W-1:0]  pfx_len_ff, pfx_len_in;
   logic [CMD_W-1:0]  bang_ff, bang_in;
   logic [CMD_W-1:0]  at_ff, at_in;
   logic [CMD_W-1:0]  cmd_val_ff, cmd_val_in;
   logic [CLEN_W-1:0] cmd_len_ff, cmd_len_in;
   logic              cmd_dig_ff, cmd_dig_in;

   logic              do_tag;
   logic              is_digit;
   logic [TC_W-1:0]   t;
   logic [TC_W-1:0]   cidx;
   logic [TC_W-1:0]   first_arg;
   logic [TC_W-1:0]   a;
   logic [TC_W-1:0]   sum_first;
   logic [TCX_W-1:0]  t_x;
   logic [TCX_W-1:0]  a_x;
   logic [TCX_W-1:0]  nargs_x;
   logic [BYTE_W-1:0] digit_val;

   always_comb begin
      pos_in      = pos_ff;
      in_token_in = in_token_ff;
      in_trail_in = in_trail_ff;
      stopped_in  = stopped_ff;
      tc_in       = tc_ff;
      has_pfx_in  = has_pfx_ff;
      pfx_len_in  = pfx_len_ff;
      bang_in     = bang_ff;
      at_in       = at_ff;
      cmd_val_in  = cmd_val_ff;
      cmd_len_in  = cmd_len_ff;
      cmd_dig_in  = cmd_dig_ff;
      do_tag      = 1'b0;
      result      = '0;

      if (!stopped_ff && (pos_ff < POS_W'(MAX_LINE))) begin
         pos_in = pos_ff + POS_W'(1);
         if (line_byte == CH_NUL) begin
            stopped_in = 1'b1;
         end else if (in_trail_ff) begin
            do_tag = 1'b1;
         end else if (line_byte == CH_SPACE) begin
            in_token_in = 1'b0;
         end else if (in_token_ff) begin
            do_tag = 1'b1;
         end else if (tc_ff < TC_W'(TOKEN_LIMIT)) begin
            tc_in       = tc_ff + TC_W'(1);
            in_token_in = 1'b1;
            if (line_byte == CH_COLON) begin
               if (pos_ff == '0) begin
                  has_pfx_in = 1'b1;
               end else begin
                  in_trail_in = 1'b1;
               end
            end else begin
               do_tag = 1'b1;
            end
         end
      end

      // tag against the token count after this word's update
      t         = tc_in - TC_W'(1);
      cidx      = has_pfx_ff ? TC_W'(1) : TC_W'(0);
      first_arg = has_pfx_ff ? TC_W'(3) : TC_W'(1);
      a         = t - first_arg;
      t_x       = TCX_W'(t);
      a_x       = TCX_W'(a);
      is_digit  = (line_byte >= CH_ZERO) && (line_byte <= CH_NINE);
      digit_val = line_byte - CH_ZERO;

      if (do_tag) begin
         if (has_pfx_ff && (t == '0)) begin
            if ((line_byte == CH_BANG) && (bang_ff == NONE_SEEN)) begin
               bang_in = CMD_W'(pfx_len_ff);
            end
            if ((line_byte == CH_AT) && (at_ff == NONE_SEEN)) begin
               at_in = CMD_W'(pfx_len_ff);
            end
            if (pfx_len_ff < SRC_SAT) begin
               pfx_len_in = pfx_len_ff + SRC_W'(1);
            end
            result.byte_role    = ROLE_PREFIX;
            result.token_number = t_x[TOKEN_W-1:0];
         end else if (t == cidx) begin
            if (!is_digit) begin
               cmd_dig_in = 1'b0;
            end
            if ((cmd_len_ff < CMD_DIGITS) && is_digit) begin
               cmd_val_in = {cmd_val_ff[CMD_W-4:0], 3'b000} + {cmd_val_ff[CMD_W-2:0], 1'b0}
                          + CMD_W'(digit_val[3:0]);
            end
            if (cmd_len_ff < CMD_LEN_CAP) begin
               cmd_len_in = cmd_len_ff + CLEN_W'(1);
            end
            result.byte_role    = ROLE_CMD;
            result.token_number = t_x[TOKEN_W-1:0];
         end else if (has_pfx_ff && (t == TC_W'(2))) begin
            result.byte_role    = ROLE_DEST;
            result.token_number = t_x[TOKEN_W-1:0];
         end else if (a < TC_W'(MAX_PARAMS)) begin
            result.byte_role       = in_trail_ff ? ROLE_TRAIL : ROLE_MIDDLE;
            result.token_number    = t_x[TOKEN_W-1:0];
            result.argument_number = a_x[ARG_W-1:0];
         end
      end

      // line summary from the updated state
      sum_first = has_pfx_in ? TC_W'(3) : TC_W'(1);
      nargs_x   = TCX_W'(tc_in - sum_first);
      if (line_end) begin
         result.line_done      = 1'b1;
         result.prefix_present = has_pfx_in;
         if (tc_in >= TC_W'(TOKEN_LIMIT)) begin
            result.parse_status = STAT_TOO_MANY;
         end else if (tc_in < sum_first) begin
            result.parse_status = STAT_TOO_FEW;
         end else if ((tc_in - sum_first) > TC_W'(MAX_PARAMS)) begin
            result.parse_status = STAT_TOO_MANY;
         end else begin
            result.parse_status   = STAT_OK;
            result.argument_count = nargs_x[ARG_W-1:0];
            if ((cmd_len_in == CMD_DIGITS) && cmd_dig_in) begin
               result.command_number = cmd_val_in;
            end
            if (has_pfx_in) begin
               if (bang_in != NONE_SEEN) begin
                  result.source_length = bang_in[SRC_W-1:0];
               end else if (at_in != NONE_SEEN) begin
                  result.source_length = at_in[SRC_W-1:0];
               end else begin
                  result.source_length = pfx_len_in;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && line_end)) begin
         pos_ff      <= '0;
         in_token_ff <= 1'b0;
         in_trail_ff <= 1'b0;
         stopped_ff  <= 1'b0;
         tc_ff       <= '0;
         has_pfx_ff  <= 1'b0;
         pfx_len_ff  <= '0;
         bang_ff     <= NONE_SEEN;
         at_ff       <= NONE_SEEN;
         cmd_val_ff  <= '0;
         cmd_len_ff  <= '0;
         cmd_dig_ff  <= 1'b1;
      end else if (step_en) begin
         pos_ff      <= pos_in;
         in_token_ff <= in_token_in;
         in_trail_ff <= in_trail_in;
         stopped_ff  <= stopped_in;
         tc_ff       <= tc_in;
         has_pfx_ff  <= has_pfx_in;
         pfx_len_ff  <= pfx_len_in;
         bang_ff     <= bang_in;
         at_ff       <= at_in;
         cmd_val_ff  <= cmd_val_in;
         cmd_len_ff  <= cmd_len_in;
         cmd_dig_ff  <= cmd_dig_in;
      end
   end

endmodule
